### src/sart_pkg.sv
// ----------------------------------------------------------------------------
// sart_pkg
// shared types and constants of the sorted address range table
// ----------------------------------------------------------------------------
package sart_pkg;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] address;
    logic [31:0] image_size;
    logic [31:0] handler_table_address;
    logic [31:0] handler_table_entries;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot_index;
    logic [31:0] found_base;
    logic [31:0] found_table_address;
    logic [31:0] table_size;
    logic [6:0]  entry_count;
    logic        overflow_seen;
  } rsp_t;

  typedef struct packed {
    logic        latch_req;
    logic        scan_start;
    logic        rd_issue;
    logic        mark_hit;
    logic        mark_miss;
    logic        shift_up_start;
    logic        shift_down_start;
    logic        copy;
    logic        write_new;
    logic        count_inc;
    logic        count_dec;
    logic        set_overflow;
    logic        load_result;
    logic [1:0]  result_status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       full;
    logic       bad_handler;
    logic       hit;
    logic       more;
    logic       rd_valid;
    logic       hit_seen;
  } sts_t;

endpackage

### src/sart_if.sv
// ----------------------------------------------------------------------------
// sart_req_if / sart_rsp_if
// valid/ready channels carrying requests and results
// ----------------------------------------------------------------------------
interface sart_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] address;
  logic [31:0] image_size;
  logic [31:0] handler_table_address;
  logic [31:0] handler_table_entries;
  modport source(output valid, req_type, address, image_size, handler_table_address,
                 handler_table_entries, input ready);
  modport sink(input valid, req_type, address, image_size, handler_table_address,
               handler_table_entries, output ready);
endinterface

interface sart_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  slot_index;
  logic [31:0] found_base;
  logic [31:0] found_table_address;
  logic [31:0] table_size;
  logic [6:0]  entry_count;
  logic        overflow_seen;
  modport source(output valid, status, slot_index, found_base, found_table_address,
                 table_size, entry_count, overflow_seen, input ready);
  modport sink(input valid, status, slot_index, found_base, found_table_address,
               table_size, entry_count, overflow_seen, output ready);
endinterface

### src/sorted_address_range_table_top.sv
// sequence: a request is checked, then scanned and shifted; a full, bad or unused
//   request is answered straight from the check
// handshake: one transaction at a time; the next request is taken the cycle after
//   the result is accepted
// reset: entry count and overflow flag clear; slot contents stay undefined
// ----------------------------------------------------------------------------
// sorted_address_range_table_top
// sorted region table with insert, remove and address lookup
// ----------------------------------------------------------------------------
module sorted_address_range_table_top #(
  parameter int TABLE_DEPTH = 64
) (
  input logic   clk,
  input logic   rst,
  sart_req_if.sink   req,
  sart_rsp_if.source rsp
);
  import sart_pkg::*;

  cmd_t cmd;
  sts_t sts;
  req_t req_d;
  rsp_t rsp_d;

  assign req_d = '{req_type: req.req_type, address: req.address, image_size: req.image_size,
                   handler_table_address: req.handler_table_address,
                   handler_table_entries: req.handler_table_entries};

  sart_ctrl u_ctrl (
    .clk, .rst, .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready), .sts, .cmd
  );

  sart_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk, .rst, .req_in(req_d), .cmd, .sts, .rsp(rsp_d)
  );

  assign rsp.status              = rsp_d.status;
  assign rsp.slot_index          = rsp_d.slot_index;
  assign rsp.found_base          = rsp_d.found_base;
  assign rsp.found_table_address = rsp_d.found_table_address;
  assign rsp.table_size          = rsp_d.table_size;
  assign rsp.entry_count         = rsp_d.entry_count;
  assign rsp.overflow_seen       = rsp_d.overflow_seen;

endmodule

### src/sart_datapath.sv
// ----------------------------------------------------------------------------
// sart_datapath
// table memories, scan pointer, shift engine, count and result register
// ----------------------------------------------------------------------------
module sart_datapath #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  sart_pkg::req_t req_in,
  input  sart_pkg::cmd_t cmd,
  output sart_pkg::sts_t sts,
  output sart_pkg::rsp_t rsp
);
  import sart_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] len;
    logic [31:0] hloc;
    logic [31:0] hsize;
  } slot_t;

  slot_t mem [TABLE_DEPTH];

  req_t          req;
  logic [CW-1:0] count;
  logic          overflow;
  logic [CW-1:0] ptr;
  logic [CW-1:0] left;
  logic [CW-1:0] pos;
  logic [CW-1:0] rd_idx;
  logic          rd_valid;
  slot_t         rd_data;
  logic          hit_cond;
  logic          hit_seen;
  logic [AW-1:0] wr_addr;
  slot_t         wr_data;
  logic          wr_en;
  logic [31:0]   diff;
  logic [31:0]   match_base;
  logic [31:0]   match_hloc;
  logic [31:0]   match_hsize;

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data <= mem[ptr[AW-1:0]];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign diff = req.address - rd_data.base;

  always_comb begin
    unique case (req.req_type)
      REQ_INSERT: hit_cond = req.address < rd_data.base;
      REQ_REMOVE: hit_cond = rd_data.base == req.address;
      REQ_LOOKUP: hit_cond = diff < rd_data.len;
      default:    hit_cond = 1'b0;
    endcase
  end

  // writes: the new entry goes to pos; shifting copies the registered read into its neighbor slot
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(pos);
    wr_data = rd_data;
    if (cmd.write_new) begin
      wr_en   = 1'b1;
      wr_data = '{base: req.address, len: req.image_size,
                  hloc: req.handler_table_address, hsize: req.handler_table_entries};
    end else if (cmd.copy && rd_valid) begin
      wr_en = 1'b1;
      if (req.req_type == REQ_INSERT) begin
        wr_addr = AW'(rd_idx + CW'(1));
      end else begin
        wr_addr = AW'(rd_idx - CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.rd_issue;
      if (cmd.count_inc) begin
        count <= count + CW'(1);
      end else if (cmd.count_dec) begin
        count <= count - CW'(1);
      end
      if (cmd.set_overflow) overflow <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) req <= req_in;
    if (cmd.scan_start) begin
      ptr  <= '0;
      left <= count;
    end else if (cmd.shift_up_start) begin
      ptr  <= count - CW'(1);
      left <= count - pos;
    end else if (cmd.shift_down_start) begin
      ptr  <= pos + CW'(1);
      left <= count - pos - CW'(1);
    end else if (cmd.rd_issue) begin
      rd_idx <= ptr;
      left   <= left - CW'(1);
      if (cmd.copy && req.req_type == REQ_INSERT) begin
        ptr <= ptr - CW'(1);
      end else begin
        ptr <= ptr + CW'(1);
      end
    end
    if (cmd.scan_start) begin
      hit_seen <= 1'b0;
    end else if (cmd.mark_hit) begin
      hit_seen <= 1'b1;
    end
    if (cmd.mark_hit) begin
      pos         <= rd_idx;
      match_base  <= rd_data.base;
      match_hloc  <= rd_data.hloc;
      match_hsize <= rd_data.hsize;
    end else if (cmd.mark_miss) begin
      pos <= count;
    end
    if (cmd.load_result) begin
      rsp.status     <= cmd.result_status;
      rsp.slot_index <= (cmd.result_status == ST_DONE) ? 6'(pos) : 6'd0;
      if (cmd.result_status == ST_DONE && req.req_type == REQ_LOOKUP) begin
        rsp.found_base          <= match_base;
        rsp.found_table_address <= match_hloc;
        rsp.table_size          <= match_hsize;
      end else begin
        rsp.found_base          <= '0;
        rsp.found_table_address <= '0;
        rsp.table_size          <= '0;
      end
      rsp.entry_count   <= 7'(count + CW'(cmd.count_inc) - CW'(cmd.count_dec));
      rsp.overflow_seen <= overflow | cmd.set_overflow;
    end
  end

  assign sts.req_type    = req.req_type;
  assign sts.full        = count >= CW'(TABLE_DEPTH);
  assign sts.bad_handler = req.handler_table_address == ALL_ONES ||
                           req.handler_table_entries == ALL_ONES;
  assign sts.hit         = rd_valid && hit_cond;
  assign sts.more        = left != '0;
  assign sts.rd_valid    = rd_valid;
  assign sts.hit_seen    = hit_seen;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH));
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.write_new && cmd.copy && rd_valid));

endmodule

### src/sart_ctrl.sv
// ----------------------------------------------------------------------------
// sart_ctrl
// request sequencer: scan, shift, write, answer
// ----------------------------------------------------------------------------
module sart_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  sart_pkg::sts_t sts,
  output sart_pkg::cmd_t cmd
);
  import sart_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_PREP  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state, state_next;

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_OUT;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.req_type == REQ_INSERT && sts.full) begin
          cmd.set_overflow  = 1'b1;
          cmd.load_result   = 1'b1;
          cmd.result_status = ST_FULL;
          state_next        = S_OUT;
        end else if (sts.req_type == REQ_INSERT && sts.bad_handler) begin
          cmd.load_result   = 1'b1;
          cmd.result_status = ST_BAD;
          state_next        = S_OUT;
        end else if (sts.req_type == REQ_INSERT || sts.req_type == REQ_REMOVE ||
                     sts.req_type == REQ_LOOKUP) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else begin
          cmd.load_result   = 1'b1;
          cmd.result_status = ST_MISS;
          state_next        = S_OUT;
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          cmd.mark_hit = 1'b1;
          state_next   = S_PREP;
        end else if (sts.more) begin
          cmd.rd_issue = 1'b1;
        end else if (!sts.rd_valid) begin
          cmd.mark_miss = 1'b1;
          state_next    = S_PREP;
        end
      end
      S_PREP: begin
        // pos is settled; decide the tail work
        unique case (sts.req_type)
          REQ_INSERT: begin
            cmd.shift_up_start = 1'b1;
            state_next         = S_SHIFT;
          end
          REQ_REMOVE: begin
            if (sts.hit_seen) begin
              cmd.shift_down_start = 1'b1;
              state_next           = S_SHIFT;
            end else begin
              cmd.load_result   = 1'b1;
              cmd.result_status = ST_MISS;
              state_next        = S_OUT;
            end
          end
          default: begin
            cmd.load_result   = 1'b1;
            cmd.result_status = sts.hit_seen ? ST_DONE : ST_MISS;
            state_next        = S_OUT;
          end
        endcase
      end
      S_SHIFT: begin
        cmd.copy = 1'b1;
        if (sts.more) begin
          cmd.rd_issue = 1'b1;
        end else if (!sts.rd_valid) begin
          cmd.load_result   = 1'b1;
          cmd.result_status = ST_DONE;
          if (sts.req_type == REQ_INSERT) begin
            cmd.write_new = 1'b1;
            cmd.count_inc = 1'b1;
          end else begin
            cmd.count_dec = 1'b1;
          end
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_state_legal: assert property (@(posedge clk) disable iff (rst) state <= S_OUT);
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid));
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid);
  a_reset_idle: assert property (@(posedge clk) rst |=> in_ready);

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks insert, remove and lookup of the sorted region table: a directed table,
// a fill past the top, then random requests, against an in-bench model of the slot table
// ----------------------------------------------------------------------------
module tb_top;
  import sart_pkg::*;

  localparam int DEPTH = 64;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [31:0] len;
    logic [31:0] hloc;
    logic [31:0] hsize;
    bit          fixed;
    logic [1:0]  st;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sart_req_if req();
  sart_rsp_if rsp();

  sorted_address_range_table_top #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0] bases[DEPTH];
  logic [31:0] lens[DEPTH];
  logic [31:0] hlocs[DEPTH];
  logic [31:0] hsizes[DEPTH];
  int unsigned regions = 0;
  bit          ovf = 1'b0;

  rsp_t pending_results[$];
  row_t directed_rows[$];
  int   mismatches = 0;
  int   results_seen = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   hold_off = 1'b0;
  int   hits = 0, fulls = 0, bads = 0;

  task automatic predict_region_op(input req_t r, output rsp_t o);
    int pos;
    o = '0;
    o.status = ST_MISS;
    if (r.req_type == REQ_INSERT) begin
      if (regions >= DEPTH) begin
        ovf = 1'b1;
        o.status = ST_FULL;
      end else if (r.handler_table_address == ALL_ONES ||
                   r.handler_table_entries == ALL_ONES) begin
        o.status = ST_BAD;
      end else begin
        pos = regions;
        for (int i = 0; i < regions; i++) begin
          if (r.address < bases[i]) begin
            pos = i;
            break;
          end
        end
        for (int i = regions; i > pos; i--) begin
          bases[i] = bases[i-1]; lens[i] = lens[i-1];
          hlocs[i] = hlocs[i-1]; hsizes[i] = hsizes[i-1];
        end
        bases[pos] = r.address; lens[pos] = r.image_size;
        hlocs[pos] = r.handler_table_address; hsizes[pos] = r.handler_table_entries;
        regions++;
        o.status = ST_DONE;
        o.slot_index = pos[5:0];
      end
    end else if (r.req_type == REQ_REMOVE) begin
      for (int i = 0; i < regions; i++) begin
        if (bases[i] == r.address) begin
          for (int k = i; k + 1 < regions; k++) begin
            bases[k] = bases[k+1]; lens[k] = lens[k+1];
            hlocs[k] = hlocs[k+1]; hsizes[k] = hsizes[k+1];
          end
          regions--;
          o.status = ST_DONE;
          o.slot_index = i[5:0];
          break;
        end
      end
    end else if (r.req_type == REQ_LOOKUP) begin
      for (int i = 0; i < regions; i++) begin
        if (32'(r.address - bases[i]) < lens[i]) begin
          o.status = ST_DONE;
          o.slot_index = i[5:0];
          o.found_base = bases[i];
          o.found_table_address = hlocs[i];
          o.table_size = hsizes[i];
          break;
        end
      end
    end
    o.entry_count = regions[6:0];
    o.overflow_seen = ovf;
  endtask

  task automatic send_request(input req_t r, input bit fixed, input logic [1:0] st);
    rsp_t e;
    @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    req.valid <= 1'b1;
    req.req_type <= r.req_type;
    req.address <= r.address;
    req.image_size <= r.image_size;
    req.handler_table_address <= r.handler_table_address;
    req.handler_table_entries <= r.handler_table_entries;
    predict_region_op(r, e);
    if (fixed && e.status != st) begin
      mismatches++;
      if (mismatches <= 10)
        $display("directed row status: predicted %0d, table says %0d", e.status, st);
    end
    if (e.status == ST_DONE && r.req_type == REQ_LOOKUP) hits++;
    if (e.status == ST_FULL) fulls++;
    if (e.status == ST_BAD) bads++;
    pending_results.push_back(e);
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    req.valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return ALL_ONES;
      2: return $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   s;
    r.req_type = 2'($urandom_range(3));
    if ($urandom_range(9) < 7 && r.req_type == REQ_NONE) r.req_type = REQ_LOOKUP;
    r.address = pick_word();
    r.image_size = pick_word();
    r.handler_table_address = $urandom_range(19) == 0 ? ALL_ONES : $urandom;
    r.handler_table_entries = $urandom_range(19) == 0 ? ALL_ONES : $urandom;
    if (r.req_type == REQ_INSERT && $urandom_range(1)) begin
      r.address = {6'($urandom_range(63)), 26'($urandom)};
      r.image_size = 32'($urandom_range(32'h0400_0000));
    end
    if (regions > 0 && $urandom_range(3) != 0) begin
      s = $urandom_range(regions - 1);
      if (r.req_type == REQ_REMOVE) r.address = bases[s];
      if (r.req_type == REQ_LOOKUP && lens[s] != 0)
        r.address = bases[s] + 32'($urandom_range(lens[s] - 1));
      if (r.req_type == REQ_INSERT && $urandom_range(3) == 0) r.address = bases[s];
    end
    return r;
  endfunction

  function automatic row_t mk(input logic [1:0] k, input logic [31:0] a, input logic [31:0] l,
                              input logic [31:0] h, input logic [31:0] z, input bit f,
                              input logic [1:0] st);
    row_t t;
    t.kind = k; t.addr = a; t.len = l; t.hloc = h; t.hsize = z; t.fixed = f; t.st = st;
    return t;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
      if (rsp.valid && rsp.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction: %p", rsp.status);
        end else begin
          rsp_t e;
          rsp_t a;
          e = pending_results.pop_front();
          a = '{rsp.status, rsp.slot_index, rsp.found_base, rsp.found_table_address,
                rsp.table_size, rsp.entry_count, rsp.overflow_seen};
          if (a !== e) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, a);
          end
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    req_t r;
    req.valid = 1'b0;
    req.req_type = REQ_INSERT;
    req.address = '0;
    req.image_size = '0;
    req.handler_table_address = '0;
    req.handler_table_entries = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty misses, extremes, bad handlers, equal bases, wrap
    directed_rows.push_back(mk(REQ_LOOKUP, 32'h0, 0, 0, 0, 1, ST_MISS));
    directed_rows.push_back(mk(REQ_REMOVE, ALL_ONES, 0, 0, 0, 1, ST_MISS));
    directed_rows.push_back(mk(REQ_NONE, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1, ST_MISS));
    directed_rows.push_back(mk(REQ_INSERT, 32'h1000, 32'h100, ALL_ONES, 5, 1, ST_BAD));
    directed_rows.push_back(mk(REQ_INSERT, 32'h1000, 32'h100, 7, ALL_ONES, 1, ST_BAD));
    directed_rows.push_back(mk(REQ_INSERT, 32'h1000, 32'h100, 32'hA, 32'h3, 1, ST_DONE));
    directed_rows.push_back(mk(REQ_INSERT, 32'h1000, 32'h10, 32'hB, 32'h4, 1, ST_DONE));
    directed_rows.push_back(mk(REQ_INSERT, 32'h0, 32'h0, 32'h0, 32'h0, 1, ST_DONE));
    directed_rows.push_back(mk(REQ_INSERT, 32'hFFFF_FF00, ALL_ONES, ALL_ONES - 1,
                               ALL_ONES - 1, 1, ST_DONE));
    directed_rows.push_back(mk(REQ_LOOKUP, 32'h0, 0, 0, 0, 0, ST_DONE));
    directed_rows.push_back(mk(REQ_LOOKUP, 32'h1008, 0, 0, 0, 0, ST_DONE));
    directed_rows.push_back(mk(REQ_LOOKUP, 32'h10F0, 0, 0, 0, 0, ST_DONE));
    directed_rows.push_back(mk(REQ_LOOKUP, ALL_ONES, 0, 0, 0, 0, ST_DONE));
    directed_rows.push_back(mk(REQ_LOOKUP, 32'h2000, 0, 0, 0, 0, ST_DONE));
    directed_rows.push_back(mk(REQ_REMOVE, 32'h1000, 0, 0, 0, 1, ST_DONE));
    directed_rows.push_back(mk(REQ_LOOKUP, 32'h1008, 0, 0, 0, 0, ST_DONE));
    directed_rows.push_back(mk(REQ_REMOVE, 32'h0, 0, 0, 0, 1, ST_DONE));
    directed_rows.push_back(mk(REQ_REMOVE, 32'h1234, 0, 0, 0, 1, ST_MISS));
    foreach (directed_rows[i]) begin
      r = '{directed_rows[i].kind, directed_rows[i].addr, directed_rows[i].len,
            directed_rows[i].hloc, directed_rows[i].hsize};
      send_request(r, directed_rows[i].fixed, directed_rows[i].st);
    end

    // fill to the top and past it, holding off the receiver meanwhile
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      while (regions < DEPTH + 3) begin
        r = '{REQ_INSERT, $urandom, $urandom, $urandom_range(1000), $urandom_range(1000)};
        send_request(r, 0, ST_DONE);
        if (regions == DEPTH && $urandom_range(3) == 0) break;
        if (ovf) break;
      end
    join
    for (int i = 0; i < 5; i++) begin
      r = '{REQ_INSERT, $urandom, $urandom, ALL_ONES, ALL_ONES};
      send_request(r, 1, ST_FULL);
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 29 : (ph == 1 ? 64 : 0);
      recv_idle_pct = ph == 0 ? 64 : (ph == 1 ? 29 : 0);
      for (int n = 0; n < 400; n++) begin
        r = random_request();
        if (regions > 48 && r.req_type == REQ_INSERT && $urandom_range(3) != 0)
          r.req_type = REQ_REMOVE;
        send_request(r, 0, ST_DONE);
      end
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 20) @(posedge clk);
    $display("covered %0d results: %0d lookup hits, %0d full-table, %0d bad-handler inserts",
             results_seen, hits, fulls, bads);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
